>>> sv/sts_pkg.sv
// Package: token codes, byte codes, token record types and character helpers for the scanner.
package sts_pkg;

  localparam int unsigned POS_W = 21;
  localparam logic [POS_W-1:0] MAX_SOURCE_BYTES = 21'd1048576;
  localparam logic [POS_W-1:0] LINE_LIMIT = 21'd1048576;
  localparam int unsigned KEYWORD_MAX_CHARS = 6;
  localparam int unsigned KW_W = 8 * KEYWORD_MAX_CHARS;
  localparam int unsigned KW_CNT_W = $clog2(KEYWORD_MAX_CHARS + 1);
  localparam int unsigned NUM_KW = 17;
  localparam int unsigned MAX_TOKENS = 4;

  localparam logic [5:0] K_LPAREN     = 6'd0;
  localparam logic [5:0] K_RPAREN     = 6'd1;
  localparam logic [5:0] K_LBRACKET   = 6'd2;
  localparam logic [5:0] K_RBRACKET   = 6'd3;
  localparam logic [5:0] K_LBRACE     = 6'd4;
  localparam logic [5:0] K_RBRACE     = 6'd5;
  localparam logic [5:0] K_COMMA      = 6'd6;
  localparam logic [5:0] K_DOT        = 6'd7;
  localparam logic [5:0] K_MINUS      = 6'd8;
  localparam logic [5:0] K_DECR       = 6'd9;
  localparam logic [5:0] K_PLUS       = 6'd10;
  localparam logic [5:0] K_INCR       = 6'd11;
  localparam logic [5:0] K_SEMICOLON  = 6'd12;
  localparam logic [5:0] K_SLASH      = 6'd13;
  localparam logic [5:0] K_STAR       = 6'd14;
  localparam logic [5:0] K_BANG       = 6'd15;
  localparam logic [5:0] K_BANG_EQ    = 6'd16;
  localparam logic [5:0] K_EQUAL      = 6'd17;
  localparam logic [5:0] K_EQ_EQ      = 6'd18;
  localparam logic [5:0] K_GREATER    = 6'd19;
  localparam logic [5:0] K_GREATER_EQ = 6'd20;
  localparam logic [5:0] K_LESS       = 6'd21;
  localparam logic [5:0] K_LESS_EQ    = 6'd22;
  localparam logic [5:0] K_ASSIGN     = 6'd23;
  localparam logic [5:0] K_IDENT      = 6'd24;
  localparam logic [5:0] K_STRING     = 6'd25;
  localparam logic [5:0] K_NUMBER     = 6'd26;
  localparam logic [5:0] K_KEYWORD0   = 6'd27;
  localparam logic [5:0] K_END        = 6'd44;
  localparam logic [5:0] K_ERR_CHAR   = 6'd45;
  localparam logic [5:0] K_ERR_STRING = 6'd46;
  localparam logic [5:0] K_NONE       = 6'd63;

  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_EQUAL    = 8'h3D;
  localparam logic [7:0] CH_LESS     = 8'h3C;
  localparam logic [7:0] CH_GREATER  = 8'h3E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_UNDER    = 8'h5F;

  // keyword text, right aligned, first character in the highest used byte
  localparam logic [KW_W-1:0] KW_TEXT [NUM_KW] = '{
    KW_W'("and"), KW_W'("class"), KW_W'("else"), KW_W'("false"), KW_W'("for"),
    KW_W'("fun"), KW_W'("if"), KW_W'("nil"), KW_W'("or"), KW_W'("print"),
    KW_W'("return"), KW_W'("style"), KW_W'("super"), KW_W'("this"), KW_W'("true"),
    KW_W'("var"), KW_W'("while")
  };

  typedef struct packed {
    logic [5:0]       kind;
    logic [POS_W-1:0] first;
    logic [POS_W-1:0] stop;
    logic [POS_W-1:0] line;
  } tok_t;

  typedef struct packed {
    tok_t [MAX_TOKENS-1:0] slot;
    logic [2:0]            count;
  } bundle_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) || (b == CH_UNDER);
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] op);
    logic [5:0] k;
    case (op)
      CH_MINUS: k = K_MINUS;
      CH_PLUS:  k = K_PLUS;
      CH_BANG:  k = K_BANG;
      CH_EQUAL: k = K_EQUAL;
      CH_LESS:  k = K_LESS;
      CH_SLASH: k = K_SLASH;
      default:  k = K_GREATER;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] pair_op(input logic [7:0] op, input logic [7:0] b);
    logic [5:0] k;
    k = K_NONE;
    if (op == CH_MINUS && b == CH_MINUS) k = K_DECR;
    else if (op == CH_PLUS && b == CH_PLUS) k = K_INCR;
    else if (op == CH_BANG && b == CH_EQUAL) k = K_BANG_EQ;
    else if (op == CH_EQUAL && b == CH_EQUAL) k = K_EQ_EQ;
    else if (op == CH_GREATER && b == CH_EQUAL) k = K_GREATER_EQ;
    else if (op == CH_LESS && b == CH_EQUAL) k = K_LESS_EQ;
    else if (op == CH_LESS && b == CH_MINUS) k = K_ASSIGN;
    return k;
  endfunction

  function automatic logic [5:0] ident_kind(input logic [KW_W-1:0] kw, input logic too_long);
    logic [5:0] k;
    k = K_IDENT;
    for (int i = 0; i < NUM_KW; i++) begin
      if (kw == KW_TEXT[i]) k = K_KEYWORD0 + 6'(i);
    end
    if (too_long) k = K_IDENT;
    return k;
  endfunction

  function automatic logic [POS_W-1:0] line_inc(input logic [POS_W-1:0] ln);
    return (ln < LINE_LIMIT) ? ln + 1'b1 : ln;
  endfunction

  function automatic bundle_t push(input bundle_t bd, input logic [5:0] k,
                                   input logic [POS_W-1:0] s, input logic [POS_W-1:0] e,
                                   input logic [POS_W-1:0] ln);
    bundle_t r;
    r = bd;
    if (bd.count < 3'(MAX_TOKENS)) begin
      r.slot[bd.count[1:0]] = '{kind: k, first: s, stop: e, line: ln};
      r.count = bd.count + 3'd1;
    end
    return r;
  endfunction

endpackage

>>> sv/sts_core.sv
// Scanner state and per-item token logic: one input transaction gives one token bundle.
module sts_core import sts_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  logic          byte_present,
  input  logic [7:0]    source_byte,
  input  logic          end_of_source,
  output bundle_t       bnd
);

  localparam logic [2:0] M_IDLE     = 3'd0;
  localparam logic [2:0] M_OP       = 3'd1;
  localparam logic [2:0] M_COMMENT  = 3'd2;
  localparam logic [2:0] M_STRING   = 3'd3;
  localparam logic [2:0] M_NUMBER   = 3'd4;
  localparam logic [2:0] M_NUMDOT   = 3'd5;
  localparam logic [2:0] M_FRACTION = 3'd6;
  localparam logic [2:0] M_IDENT    = 3'd7;

  logic [2:0]          mode_r, mode_nxt;
  logic [7:0]          op_r, op_nxt;
  logic [POS_W-1:0]    tb_r, tb_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    line_r, line_nxt;
  logic [KW_W-1:0]     kw_r, kw_nxt;
  logic [KW_CNT_W-1:0] kwn_r, kwn_nxt;
  logic                long_r, long_nxt;

  logic [POS_W-1:0] cur, nxt, p;
  logic [7:0]       b;
  logic [5:0]       k2;
  logic             do_idle;

  always_comb begin
    mode_nxt = mode_r;
    op_nxt   = op_r;
    tb_nxt   = tb_r;
    pos_nxt  = pos_r;
    line_nxt = line_r;
    kw_nxt   = kw_r;
    kwn_nxt  = kwn_r;
    long_nxt = long_r;
    bnd      = '0;
    do_idle  = 1'b0;
    b        = source_byte;
    cur      = pos_r;
    nxt      = (pos_r < MAX_SOURCE_BYTES) ? pos_r + 1'b1 : pos_r;
    k2       = pair_op(op_r, b);
    p        = '0;
    if (byte_present) begin
      unique case (mode_r)
        M_IDLE: do_idle = 1'b1;
        M_OP: begin
          if (k2 != K_NONE) begin
            bnd = push(bnd, k2, tb_r, nxt, line_nxt);
            mode_nxt = M_IDLE;
          end else if (op_r == CH_SLASH && b == CH_SLASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            bnd = push(bnd, single_op(op_r), tb_r, cur, line_nxt);
            do_idle = 1'b1;
          end
        end
        M_COMMENT: do_idle = (b == CH_NL);
        M_STRING: begin
          if (b == CH_QUOTE) begin
            bnd = push(bnd, K_STRING, tb_r, nxt, line_nxt);
            mode_nxt = M_IDLE;
          end else if (b == CH_NL) begin
            line_nxt = line_inc(line_r);
          end
        end
        M_NUMBER: begin
          if (b == CH_DOT) begin
            mode_nxt = M_NUMDOT;
          end else if (!is_digit(b)) begin
            bnd = push(bnd, K_NUMBER, tb_r, cur, line_nxt);
            do_idle = 1'b1;
          end
        end
        M_NUMDOT: begin
          if (is_digit(b)) begin
            mode_nxt = M_FRACTION;
          end else begin
            bnd = push(bnd, K_NUMBER, tb_r, cur - 1'b1, line_nxt);
            bnd = push(bnd, K_DOT, cur - 1'b1, cur, line_nxt);
            do_idle = 1'b1;
          end
        end
        M_FRACTION: begin
          if (!is_digit(b)) begin
            bnd = push(bnd, K_NUMBER, tb_r, cur, line_nxt);
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(b) || is_digit(b)) begin
            if (kwn_r < KW_CNT_W'(KEYWORD_MAX_CHARS)) begin
              kw_nxt  = {kw_r[KW_W-9:0], b};
              kwn_nxt = kwn_r + 1'b1;
            end else begin
              long_nxt = 1'b1;
            end
          end else begin
            bnd = push(bnd, ident_kind(kw_r, long_r), tb_r, cur, line_nxt);
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      if (do_idle) begin
        mode_nxt = M_IDLE;
        case (b) inside
          CH_LPAREN:   bnd = push(bnd, K_LPAREN, cur, nxt, line_nxt);
          CH_RPAREN:   bnd = push(bnd, K_RPAREN, cur, nxt, line_nxt);
          CH_LBRACKET: bnd = push(bnd, K_LBRACKET, cur, nxt, line_nxt);
          CH_RBRACKET: bnd = push(bnd, K_RBRACKET, cur, nxt, line_nxt);
          CH_LBRACE:   bnd = push(bnd, K_LBRACE, cur, nxt, line_nxt);
          CH_RBRACE:   bnd = push(bnd, K_RBRACE, cur, nxt, line_nxt);
          CH_COMMA:    bnd = push(bnd, K_COMMA, cur, nxt, line_nxt);
          CH_DOT:      bnd = push(bnd, K_DOT, cur, nxt, line_nxt);
          CH_SEMI:     bnd = push(bnd, K_SEMICOLON, cur, nxt, line_nxt);
          CH_STAR:     bnd = push(bnd, K_STAR, cur, nxt, line_nxt);
          CH_MINUS, CH_PLUS, CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH: begin
            mode_nxt = M_OP;
            op_nxt   = b;
            tb_nxt   = cur;
          end
          CH_SPACE, CH_CR, CH_TAB: ;
          CH_NL: line_nxt = line_inc(line_r);
          CH_QUOTE: begin
            mode_nxt = M_STRING;
            tb_nxt   = cur;
          end
          default: begin
            if (is_digit(b)) begin
              mode_nxt = M_NUMBER;
              tb_nxt   = cur;
            end else if (is_alpha(b)) begin
              mode_nxt = M_IDENT;
              tb_nxt   = cur;
              kw_nxt   = KW_W'(b);
              kwn_nxt  = KW_CNT_W'(1);
              long_nxt = 1'b0;
            end else begin
              bnd = push(bnd, K_ERR_CHAR, cur, nxt, line_nxt);
            end
          end
        endcase
      end
      pos_nxt = nxt;
    end

    if (end_of_source) begin
      p = pos_nxt;
      case (mode_nxt)
        M_OP:                 bnd = push(bnd, single_op(op_nxt), tb_nxt, p, line_nxt);
        M_STRING:             bnd = push(bnd, K_ERR_STRING, tb_nxt, p, line_nxt);
        M_NUMBER, M_FRACTION: bnd = push(bnd, K_NUMBER, tb_nxt, p, line_nxt);
        M_NUMDOT: begin
          bnd = push(bnd, K_NUMBER, tb_nxt, p - 1'b1, line_nxt);
          bnd = push(bnd, K_DOT, p - 1'b1, p, line_nxt);
        end
        M_IDENT:              bnd = push(bnd, ident_kind(kw_nxt, long_nxt), tb_nxt, p, line_nxt);
        default: ;
      endcase
      bnd = push(bnd, K_END, p, p, line_nxt);
      mode_nxt = M_IDLE;
      op_nxt   = '0;
      tb_nxt   = '0;
      pos_nxt  = '0;
      line_nxt = POS_W'(1);
      kw_nxt   = '0;
      kwn_nxt  = '0;
      long_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      op_r   <= '0;
      tb_r   <= '0;
      pos_r  <= '0;
      line_r <= POS_W'(1);
      kw_r   <= '0;
      kwn_r  <= '0;
      long_r <= 1'b0;
    end else if (adv) begin
      mode_r <= mode_nxt;
      op_r   <= op_nxt;
      tb_r   <= tb_nxt;
      pos_r  <= pos_nxt;
      line_r <= line_nxt;
      kw_r   <= kw_nxt;
      kwn_r  <= kwn_nxt;
      long_r <= long_nxt;
    end
  end

  a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n) line_r != '0)
    else $error("line counter reached zero");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MAX_SOURCE_BYTES && tb_r <= pos_r)
    else $error("position out of range");
  a_kw_count: assert property (@(posedge clk) disable iff (!rst_n)
    kwn_r <= KW_CNT_W'(KEYWORD_MAX_CHARS))
    else $error("keyword prefix overfilled");

endmodule

>>> sv/sts_out.sv
// Token bundle register and serializer onto the result channel.
module sts_out import sts_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  bundle_t      bnd,
  output logic         can_load,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata,
  output logic         out_tlast
);

  bundle_t    bnd_r;
  logic       valid_r;
  logic [1:0] idx_r;
  tok_t       tok;
  logic [19:0] start;
  logic [20:0] length;
  logic       last, done;

  assign tok    = bnd_r.slot[idx_r];
  assign start  = (tok.first >= MAX_SOURCE_BYTES) ? 20'hFFFFF : tok.first[19:0];
  assign length = (tok.stop > tok.first) ? tok.stop - tok.first : '0;
  assign last   = ({1'b0, idx_r} == bnd_r.count - 3'd1);
  assign done   = valid_r && out_tready && last;
  assign can_load = !valid_r || done;

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0, tok.line, length, start, tok.kind};
  assign out_tlast  = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (done) begin
      valid_r <= 1'b0;
    end else if (valid_r && out_tready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) bnd_r <= bnd;
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (bnd_r.count != '0 && {1'b0, idx_r} < bnd_r.count))
    else $error("token index outside bundle");
  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> can_load)
    else $error("bundle overwritten before drained");
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_tready && !last && !load) |=> idx_r == $past(idx_r) + 2'd1)
    else $error("token index did not advance");

endmodule

>>> sv/script_token_scanner_unit.sv
// Top level: input register, scanner core and token serializer.
// An input transaction passes the input register and the token bundle register before
// its first token reaches the result channel. One input transaction per cycle while each
// yields at most one token and out_tready stays high; more tokens hold the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the scanner
// to line 1, position 0, between tokens.
module script_token_scanner_unit import sts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] source_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_source
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [5:0] token_kind, [25:6] token_start,
                                  // [46:26] token_length, [67:47] line_number, [71:68] zero
  output logic        out_tlast   // last_of_run
);

  logic       inv_r;
  logic [7:0] byte_r;
  logic       pres_r, eos_r;
  logic       can_load, adv;
  bundle_t    bnd;

  assign adv       = inv_r && can_load;
  assign in_tready = !inv_r || can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_tready) begin
      inv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
      pres_r <= in_tuser;
      eos_r  <= in_tlast;
    end
  end

  sts_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .byte_present  (pres_r),
    .source_byte   (byte_r),
    .end_of_source (eos_r),
    .bnd           (bnd)
  );

  sts_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (adv && bnd.count != '0),
    .bnd        (bnd),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> bench/script_token_scanner_unit_test.sv
// Testbench for script_token_scanner_unit: source byte streams checked against a token predictor.
module script_token_scanner_unit_test import sts_pkg::*; ();

  localparam int IDLE_M = 0, OP_M = 1, COMMENT_M = 2, STRING_M = 3, NUMBER_M = 4,
                 NUMDOT_M = 5, FRACTION_M = 6, IDENT_M = 7;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [5:0]  kind;
    logic [19:0] start;
    logic [20:0] length;
    logic [20:0] line;
    logic        last;
  } token_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tlast;

  script_token_scanner_unit dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int          mode;
  logic [7:0]  op_char;
  logic [20:0] tok_begin;
  logic [20:0] pos;
  logic [20:0] line_cnt;
  logic [47:0] kw_prefix;
  logic        too_long;
  token_t      step_tokens[$];
  token_t      expected_tokens[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          stall_off = 1'b0;

  function automatic void clear_scanner();
    mode = IDLE_M; op_char = '0; tok_begin = '0; pos = '0; line_cnt = 21'd1;
    kw_prefix = '0; too_long = 1'b0;
  endfunction

  function automatic void add_token(logic [5:0] k, logic [20:0] b, logic [20:0] e);
    token_t t;
    if (step_tokens.size() >= MAX_TOKENS) return;
    t.kind = k;
    t.start = (b < MAX_SOURCE_BYTES) ? b[19:0] : 20'hFFFFF;
    t.length = (e > b) ? e - b : '0;
    t.line = line_cnt;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void bump_line();
    if (line_cnt < LINE_LIMIT) line_cnt++;
  endfunction

  function automatic bit digit_ch(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit alpha_ch(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == CH_UNDER;
  endfunction

  function automatic logic [5:0] word_kind();
    string words[17] = '{"and", "class", "else", "false", "for", "fun", "if", "nil", "or",
                         "print", "return", "style", "super", "this", "true", "var", "while"};
    logic [47:0] v;
    if (too_long) return K_IDENT;
    for (int k = 0; k < 17; k++) begin
      v = '0;
      for (int i = 0; i < words[k].len(); i++) v[8*i +: 8] = words[k][i];
      if (v == kw_prefix) return K_KEYWORD0 + 6'(k);
    end
    return K_IDENT;
  endfunction

  function automatic logic [5:0] lone_op(logic [7:0] c);
    case (c)
      CH_MINUS: return K_MINUS;
      CH_PLUS:  return K_PLUS;
      CH_BANG:  return K_BANG;
      CH_EQUAL: return K_EQUAL;
      CH_LESS:  return K_LESS;
      CH_SLASH: return K_SLASH;
      default:  return K_GREATER;
    endcase
  endfunction

  function automatic void start_token(logic [7:0] b, logic [20:0] cur, logic [20:0] nxt);
    case (b)
      CH_LPAREN:   add_token(K_LPAREN, cur, nxt);
      CH_RPAREN:   add_token(K_RPAREN, cur, nxt);
      CH_LBRACKET: add_token(K_LBRACKET, cur, nxt);
      CH_RBRACKET: add_token(K_RBRACKET, cur, nxt);
      CH_LBRACE:   add_token(K_LBRACE, cur, nxt);
      CH_RBRACE:   add_token(K_RBRACE, cur, nxt);
      CH_COMMA:    add_token(K_COMMA, cur, nxt);
      CH_DOT:      add_token(K_DOT, cur, nxt);
      CH_SEMI:     add_token(K_SEMICOLON, cur, nxt);
      CH_STAR:     add_token(K_STAR, cur, nxt);
      CH_MINUS, CH_PLUS, CH_BANG, CH_EQUAL, CH_LESS, CH_GREATER, CH_SLASH: begin
        mode = OP_M; op_char = b; tok_begin = cur;
      end
      CH_SPACE, CH_CR, CH_TAB: ;
      CH_NL: bump_line();
      CH_QUOTE: begin
        mode = STRING_M; tok_begin = cur;
      end
      default: begin
        if (digit_ch(b)) begin
          mode = NUMBER_M; tok_begin = cur;
        end else if (alpha_ch(b)) begin
          mode = IDENT_M; tok_begin = cur; kw_prefix = {40'd0, b}; too_long = 1'b0;
        end else begin
          add_token(K_ERR_CHAR, cur, nxt);
        end
      end
    endcase
  endfunction

  // returns 1 when the byte was absorbed by the open token
  function automatic bit continue_token(logic [7:0] b, logic [20:0] cur, logic [20:0] nxt);
    logic [5:0] k;
    int i;
    case (mode)
      OP_M: begin
        k = K_NONE;
        if (op_char == CH_MINUS && b == CH_MINUS) k = K_DECR;
        else if (op_char == CH_PLUS && b == CH_PLUS) k = K_INCR;
        else if (op_char == CH_BANG && b == CH_EQUAL) k = K_BANG_EQ;
        else if (op_char == CH_EQUAL && b == CH_EQUAL) k = K_EQ_EQ;
        else if (op_char == CH_GREATER && b == CH_EQUAL) k = K_GREATER_EQ;
        else if (op_char == CH_LESS && b == CH_EQUAL) k = K_LESS_EQ;
        else if (op_char == CH_LESS && b == CH_MINUS) k = K_ASSIGN;
        else if (op_char == CH_SLASH && b == CH_SLASH) begin
          mode = COMMENT_M;
          return 1;
        end
        if (k != K_NONE) begin
          add_token(k, tok_begin, nxt);
          mode = IDLE_M;
          return 1;
        end
        add_token(lone_op(op_char), tok_begin, cur);
        return 0;
      end
      COMMENT_M: return b != CH_NL;
      STRING_M: begin
        if (b == CH_QUOTE) begin
          add_token(K_STRING, tok_begin, nxt);
          mode = IDLE_M;
        end else if (b == CH_NL) begin
          bump_line();
        end
        return 1;
      end
      NUMBER_M: begin
        if (digit_ch(b)) return 1;
        if (b == CH_DOT) begin
          mode = NUMDOT_M;
          return 1;
        end
        add_token(K_NUMBER, tok_begin, cur);
        return 0;
      end
      NUMDOT_M: begin
        if (digit_ch(b)) begin
          mode = FRACTION_M;
          return 1;
        end
        add_token(K_NUMBER, tok_begin, cur - 21'd1);
        add_token(K_DOT, cur - 21'd1, cur);
        return 0;
      end
      FRACTION_M: begin
        if (digit_ch(b)) return 1;
        add_token(K_NUMBER, tok_begin, cur);
        return 0;
      end
      IDENT_M: begin
        if (alpha_ch(b) || digit_ch(b)) begin
          for (i = 0; i < KEYWORD_MAX_CHARS; i++)
            if (kw_prefix[8*i +: 8] == 8'd0) break;
          if (i < KEYWORD_MAX_CHARS) kw_prefix[8*i +: 8] = b;
          else too_long = 1'b1;
          return 1;
        end
        add_token(word_kind(), tok_begin, cur);
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void flush_source();
    logic [20:0] p;
    p = pos;
    case (mode)
      OP_M:     add_token(lone_op(op_char), tok_begin, p);
      STRING_M: add_token(K_ERR_STRING, tok_begin, p);
      NUMBER_M, FRACTION_M: add_token(K_NUMBER, tok_begin, p);
      NUMDOT_M: begin
        add_token(K_NUMBER, tok_begin, p - 21'd1);
        add_token(K_DOT, p - 21'd1, p);
      end
      IDENT_M: add_token(word_kind(), tok_begin, p);
      default: ;
    endcase
    add_token(K_END, p, p);
  endfunction

  function automatic void predict_tokens(bit present, logic [7:0] b, bit eos);
    logic [20:0] cur, nxt;
    step_tokens.delete();
    if (present) begin
      cur = pos;
      nxt = (cur < MAX_SOURCE_BYTES) ? cur + 21'd1 : MAX_SOURCE_BYTES;
      if (mode == IDLE_M || !continue_token(b, cur, nxt)) begin
        if (mode != COMMENT_M || b == CH_NL) begin
          mode = IDLE_M;
          start_token(b, cur, nxt);
        end
      end
      pos = nxt;
    end
    if (eos) begin
      flush_source();
      clear_scanner();
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
  endfunction

  task automatic send_item(bit present, logic [7:0] b, bit eos);
    int g;
    g = stall_off ? 0 : gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= present;
    in_tlast <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_tokens(present, b, eos);
  endtask

  task automatic send_text(string s, bit eos);
    for (int i = 0; i < s.len(); i++) send_item(1'b1, s[i], eos && i == s.len() - 1);
  endtask

  task automatic end_source();
    send_item(1'b0, 8'($urandom_range(0, 255)), 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      out_tready <= stall_off ? 1'b1 : ($urandom_range(0, 3) != 0);
      if (out_tvalid && out_tready) begin
        token_t e;
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected token %h last %b", $time, out_tdata, out_tlast);
          errors++;
        end else begin
          e = expected_tokens.pop_front();
          if (out_tdata[5:0] !== e.kind || out_tdata[25:6] !== e.start ||
              out_tdata[46:26] !== e.length || out_tdata[67:47] !== e.line ||
              out_tdata[71:68] !== 4'd0 || out_tlast !== e.last) begin
            $display("%0t: expected kind %0d start %0d len %0d line %0d last %b",
                     $time, e.kind, e.start, e.length, e.line, e.last);
            $display("%0t: actual   kind %0d start %0d len %0d line %0d last %b",
                     $time, out_tdata[5:0], out_tdata[25:6], out_tdata[46:26],
                     out_tdata[67:47], out_tlast);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("script_token_scanner_unit test failed");
      $finish;
    end
  end

  task automatic test_operators();
    send_text("()[]{},.;*- -- + ++ ! != = == > >= < <= <- / ", 1'b0);
    send_text("// note\n-", 1'b1);
  endtask

  task automatic test_literals();
    send_text("\"a\nb\" 12.x 3.25 7. and class else false for fun if nil or print ", 1'b0);
    send_text("return style super this true var while _Ab9 returned", 1'b1);
    send_text("abcdefgh while", 1'b0);
    end_source();
  endtask

  task automatic test_edge_cases();
    send_item(1'b0, 8'hFF, 1'b0);
    send_item(1'b1, 8'h00, 1'b0);
    send_item(1'b1, 8'hFF, 1'b0);
    send_item(1'b1, 8'h80, 1'b0);
    send_text("\"open", 1'b1);
    send_text("x // open", 1'b1);
    send_text("42", 1'b1);
    send_text("<", 1'b1);
    end_source();
  endtask

  task automatic test_random_sources();
    string frags[24] = '{"var ", "x", "_y1", "while", "return ", "12", "3.5", "9.",
                         "\"s\"", "\"m\nl\"", "// c\n", "\n", " ", "\t", "<-", "<=",
                         "++", "--", "!=", "==", "(", "};", ",", "style "};
    int n;
    n = 0;
    while (n < 30) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                  $urandom_range(0, 9) == 0);
        n++;
      end else begin
        string f;
        f = frags[$urandom_range(0, 23)];
        send_text(f, $urandom_range(0, 15) == 0);
        n += f.len();
      end
    end
    end_source();
  endtask

  task automatic test_steady_flow();
    stall_off = 1'b1;
    send_text("if (a1 >= 20) { print a1 + 1; }", 1'b1);
    stall_off = 1'b0;
  endtask

  initial begin
    clear_scanner();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_operators();
    test_literals();
    test_edge_cases();
    test_steady_flow();
    test_random_sources();
    in_tvalid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_tokens.size() == 0) begin
      $display("script_token_scanner_unit test passed");
    end else begin
      $display("script_token_scanner_unit test failed");
    end
    $finish;
  end

endmodule
